// File: rtl/renc_pkg.sv
// Shared constants and types for the rotary encoder front end.
`default_nettype none

package renc_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_DECODE_MODE  = 2'd0;
	localparam logic [1:0] REG_ENC_DEBOUNCE = 2'd1;
	localparam logic [1:0] REG_BTN_DEBOUNCE = 2'd2;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	localparam int TIME_W   = 32;
	localparam int POS_W    = 8;
	localparam int STEP_W   = 2;
	localparam int IN_W     = 40;  // 35 payload bits padded to bytes
	localparam int OUT_W    = 48;  // 44 payload bits padded to bytes

	localparam logic        MODE_TABLE = 1'b0;
	localparam logic        MODE_EDGE  = 1'b1;

	// Bit i set when transition code i is a legal Gray step
	localparam logic [15:0] QUAD_VALID = 16'b0110_1001_1001_0110;
	localparam logic [7:0]  HIST_CW    = 8'h2b;
	localparam logic [7:0]  HIST_CCW   = 8'h17;

	localparam logic [STEP_W-1:0] STEP_NONE = 2'b00;
	localparam logic [STEP_W-1:0] STEP_CW   = 2'b01;
	localparam logic [STEP_W-1:0] STEP_CCW  = 2'b11;

	localparam logic [7:0]  ENC_DEBOUNCE_RST = 8'd1;
	localparam logic [15:0] BTN_DEBOUNCE_RST = 16'd5;

	typedef struct packed {
		logic              pin_a;
		logic              pin_b;
		logic              button_pin;
		logic [TIME_W-1:0] now_ms;
	} sample_t;

	typedef struct packed {
		logic [STEP_W-1:0] step;
		logic [POS_W-1:0]  position;
		logic              button_pressing;
		logic              button_changed;
		logic [TIME_W-1:0] press_duration_ms;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/rotary_encoder_front_end.sv
// Rotary encoder front end: quadrature / edge decode with debounced button.
// A taken word is held in the input stage while the output stage stalls.
// Throughput: one word per cycle while m_tready is high (input and output stage).
// Decoder state is updated as a word moves from the input stage to the output stage.
// Reset (arst_n low, asynchronous) clears the valid flags of both stages, the decoder
// state and the registers to their defaults; s_tready is high right after release.
`default_nettype none

module rotary_encoder_front_end (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// tdata: pin_a[0], pin_b[1], button_pin[2], now_ms[34:3], zero pad [39:35]
	input  wire logic [renc_pkg::IN_W-1:0]      s_tdata,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// tdata: step[1:0], position[9:2], button_pressing[10], button_changed[11],
	//        press_duration_ms[43:12], zero pad [47:44]
	output logic [renc_pkg::OUT_W-1:0]          m_tdata,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	input  wire logic                           cfg_we,
	input  wire logic [renc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [renc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import renc_pkg::*;

	// Configuration
	logic              decode_mode_q;
	logic [7:0]        enc_debounce_q;
	logic [15:0]       btn_debounce_q;

	// Pipeline
	sample_t           sample_s1;
	logic              valid_s1;
	result_t           result_s2;
	logic              valid_s2;
	logic              advance;

	// Decoder state
	logic [3:0]        quad_code_q;
	logic [7:0]        history_q;
	logic              a_seen_q;
	logic              b_seen_q;
	logic [TIME_W-1:0] enc_edge_ms_q;
	logic [POS_W-1:0]  position_q;
	logic              btn_prev_q;
	logic [TIME_W-1:0] btn_edge_ms_q;
	logic [TIME_W-1:0] press_start_q;
	logic [TIME_W-1:0] press_end_q;
	logic              held_q;

	// Next state
	logic [3:0]        quad_code_d;
	logic [7:0]        history_d;
	logic [STEP_W-1:0] step_d;
	logic [TIME_W-1:0] enc_edge_ms_d;
	logic [POS_W-1:0]  position_d;
	logic [TIME_W-1:0] btn_edge_ms_d;
	logic [TIME_W-1:0] press_start_d;
	logic [TIME_W-1:0] press_end_d;
	logic              held_d;
	logic              changed_d;
	logic [TIME_W-1:0] duration_d;

	logic              a_chg;
	logic              b_chg;
	logic              enc_gap_ok;
	logic              btn_gap_ok;
	logic [TIME_W-1:0] enc_dt;
	logic [TIME_W-1:0] btn_dt;
	logic [TIME_W-1:0] press_diff;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;
	// step in the lowest bits
	assign m_tdata  = {4'b0, result_s2.press_duration_ms, result_s2.button_changed,
		result_s2.button_pressing, result_s2.position, result_s2.step};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_mode_q  <= MODE_TABLE;
			enc_debounce_q <= ENC_DEBOUNCE_RST;
			btn_debounce_q <= BTN_DEBOUNCE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DECODE_MODE:  decode_mode_q  <= cfg_data[0];
				REG_ENC_DEBOUNCE: enc_debounce_q <= cfg_data[7:0];
				REG_BTN_DEBOUNCE: btn_debounce_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			sample_s1 <= {s_tdata[0], s_tdata[1], s_tdata[2], s_tdata[34:3]};
		end
	end

	always_comb begin
		// Table decode
		quad_code_d = {quad_code_q[1:0], sample_s1.pin_a, sample_s1.pin_b};
		history_d   = history_q;
		step_d      = STEP_NONE;
		if (QUAD_VALID[quad_code_d]) begin
			history_d = {history_q[3:0], quad_code_d};
			if (history_d == HIST_CW) begin
				step_d = STEP_CW;
			end else if (history_d == HIST_CCW) begin
				step_d = STEP_CCW;
			end
		end

		// Edge decode: channel A first; a B edge in the same word as an A edge is not counted
		a_chg      = sample_s1.pin_a != a_seen_q;
		b_chg      = sample_s1.pin_b != b_seen_q;
		enc_dt     = sample_s1.now_ms - enc_edge_ms_q;
		enc_gap_ok = enc_dt > {{(TIME_W - 8){1'b0}}, enc_debounce_q};
		position_d = position_q;
		if (a_chg && sample_s1.pin_a && !b_seen_q && enc_gap_ok) begin
			position_d = position_q + POS_W'(1);
		end else if (!a_chg && b_chg && sample_s1.pin_b && !sample_s1.pin_a && enc_gap_ok) begin
			position_d = position_q - POS_W'(1);
		end
		enc_edge_ms_d = (a_chg || b_chg) ? sample_s1.now_ms : enc_edge_ms_q;

		// Button
		btn_dt        = sample_s1.now_ms - btn_edge_ms_q;
		btn_gap_ok    = btn_dt > {{(TIME_W - 16){1'b0}}, btn_debounce_q};
		changed_d     = (sample_s1.button_pin != btn_prev_q) && btn_gap_ok;
		btn_edge_ms_d = btn_edge_ms_q;
		press_start_d = press_start_q;
		press_end_d   = press_end_q;
		held_d        = held_q;
		if (changed_d) begin
			btn_edge_ms_d = sample_s1.now_ms;
			held_d        = !sample_s1.button_pin;
			if (!sample_s1.button_pin) begin
				press_start_d = sample_s1.now_ms;
			end else begin
				press_end_d = sample_s1.now_ms;
			end
		end

		// Mode 0 leaves edge and button state frozen; mode 1 leaves table state frozen
		if (decode_mode_q == MODE_TABLE) begin
			position_d    = position_q;
			enc_edge_ms_d = enc_edge_ms_q;
			changed_d     = 1'b0;
			btn_edge_ms_d = btn_edge_ms_q;
			press_start_d = press_start_q;
			press_end_d   = press_end_q;
			held_d        = held_q;
		end else begin
			quad_code_d = quad_code_q;
			history_d   = history_q;
			step_d      = STEP_NONE;
		end

		press_diff = press_end_d - press_start_d;
		duration_d = (press_end_d > press_start_d) ? press_diff : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2      <= 1'b0;
			quad_code_q   <= '0;
			history_q     <= '0;
			a_seen_q      <= 1'b0;
			b_seen_q      <= 1'b0;
			enc_edge_ms_q <= '0;
			position_q    <= '0;
			btn_prev_q    <= 1'b1;
			btn_edge_ms_q <= '0;
			press_start_q <= '0;
			press_end_q   <= '0;
			held_q        <= 1'b0;
		end else begin
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
			if (advance) begin
				quad_code_q   <= quad_code_d;
				history_q     <= history_d;
				enc_edge_ms_q <= enc_edge_ms_d;
				position_q    <= position_d;
				btn_edge_ms_q <= btn_edge_ms_d;
				press_start_q <= press_start_d;
				press_end_q   <= press_end_d;
				held_q        <= held_d;
				if (decode_mode_q == MODE_EDGE) begin
					a_seen_q   <= sample_s1.pin_a;
					b_seen_q   <= sample_s1.pin_b;
					btn_prev_q <= sample_s1.button_pin;
				end
			end
		end
	end

	// Output stage
	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2.step              <= step_d;
			result_s2.position          <= position_d;
			result_s2.button_pressing   <= held_d;
			result_s2.button_changed    <= changed_d;
			result_s2.press_duration_ms <= duration_d;
		end
	end

endmodule

`default_nettype wire

// File: tb/sv/rotary_encoder_front_end_tb.sv
// Self-checking testbench for the rotary encoder front end: directed and random pin samples.
`timescale 1ns / 100ps

module rotary_encoder_front_end_tb;
	import renc_pkg::*;

	localparam int HOLD_CYCLES = 200;

	logic                   clk = 1'b0;
	logic                   arst_n;
	// tdata: pin_a[0], pin_b[1], button_pin[2], now_ms[34:3], zero pad [39:35]
	logic [IN_W-1:0]        s_tdata;
	logic                   s_tvalid;
	wire                    s_tready;
	// tdata: step[1:0], position[9:2], button_pressing[10], button_changed[11],
	//        press_duration_ms[43:12], zero pad [47:44]
	wire  [OUT_W-1:0]       m_tdata;
	wire                    m_tvalid;
	logic                   m_tready;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// decoder copy kept by the testbench
	logic        cfg_mode;
	logic [7:0]  cfg_enc_db;
	logic [15:0] cfg_btn_db;
	logic [3:0]  quad_code;
	logic [7:0]  quad_hist;
	logic        a_seen, b_seen;
	logic [31:0] enc_edge_ms;
	logic [7:0]  pos_count;
	logic        btn_level_seen;
	logic [31:0] btn_edge_ms, press_start_ms, press_end_ms;
	logic        held;

	result_t     pending_results[$];
	int          mismatch_count = 0;
	int          sender_idle_pct = 0;
	int          stall_pct = 0;
	bit          hold_toggle = 1'b0;

	// random walk state
	int          gray_idx = 0;
	bit          turn_cw = 1'b1;
	bit          btn_drive = 1'b1;
	logic [31:0] wall_ms = '0;

	rotary_encoder_front_end dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("rotary_encoder_front_end test failed");
		$finish;
	end

	function automatic void reset_decoder();
		cfg_mode       = MODE_TABLE;
		cfg_enc_db     = ENC_DEBOUNCE_RST;
		cfg_btn_db     = BTN_DEBOUNCE_RST;
		quad_code      = '0;
		quad_hist      = '0;
		a_seen         = 1'b0;
		b_seen         = 1'b0;
		enc_edge_ms    = '0;
		pos_count      = '0;
		btn_level_seen = 1'b1;
		btn_edge_ms    = '0;
		press_start_ms = '0;
		press_end_ms   = '0;
		held           = 1'b0;
	endfunction

	function automatic result_t decode_sample(input logic a, input logic b, input logic btn,
		input logic [31:0] t);
		result_t     r;
		logic [31:0] enc_dt;
		logic [31:0] btn_dt;
		r = '0;
		if (cfg_mode == MODE_TABLE) begin
			quad_code = {quad_code[1:0], a, b};
			if (QUAD_VALID[quad_code]) begin
				quad_hist = {quad_hist[3:0], quad_code};
				if (quad_hist == HIST_CW)
					r.step = STEP_CW;
				else if (quad_hist == HIST_CCW)
					r.step = STEP_CCW;
			end
		end else begin
			if (a != a_seen) begin
				enc_dt = t - enc_edge_ms;
				a_seen = a;
				if (a && !b_seen && enc_dt > 32'(cfg_enc_db))
					pos_count = pos_count + 8'd1;
				enc_edge_ms = t;
			end
			// B sees A's level and edge time from this same sample
			if (b != b_seen) begin
				enc_dt = t - enc_edge_ms;
				b_seen = b;
				if (b && !a_seen && enc_dt > 32'(cfg_enc_db))
					pos_count = pos_count - 8'd1;
				enc_edge_ms = t;
			end
			btn_dt = t - btn_edge_ms;
			if (btn != btn_level_seen && btn_dt > 32'(cfg_btn_db)) begin
				if (!btn) begin
					press_start_ms = t;
					held = 1'b1;
				end else begin
					press_end_ms = t;
					held = 1'b0;
				end
				r.button_changed = 1'b1;
				btn_edge_ms = t;
			end
			btn_level_seen = btn;
		end
		r.position          = pos_count;
		r.button_pressing   = held;
		r.press_duration_ms = (press_end_ms > press_start_ms) ? press_end_ms - press_start_ms : '0;
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	task automatic check_word(input logic [OUT_W-1:0] word);
		result_t want;
		if (pending_results.size() == 0) begin
			mismatch_count++;
			$display("%0t: unexpected word, expected none, actual %h", $time, word);
		end else begin
			want = pending_results.pop_front();
			compare_field("step", 32'(want.step), 32'(word[1:0]));
			compare_field("position", 32'(want.position), 32'(word[9:2]));
			compare_field("button_pressing", 32'(want.button_pressing), 32'(word[10]));
			compare_field("button_changed", 32'(want.button_changed), 32'(word[11]));
			compare_field("press_duration_ms", want.press_duration_ms, word[43:12]);
		end
	endtask

	// result side: random stalls plus an occasional long hold-off
	initial begin
		int hold_left;
		bit hold_seen;
		hold_left = 0;
		hold_seen = 1'b0;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				check_word(m_tdata);
			if (hold_toggle != hold_seen) begin
				hold_seen = hold_toggle;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic send_sample(input logic a, input logic b, input logic btn, input logic [31:0] t);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tdata  <= {5'b0, t, btn, b, a};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_results.push_back(decode_sample(a, b, btn, t));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// only legal while the block is empty
	task automatic write_config(input logic mode, input logic [7:0] enc_db, input logic [15:0] btn_db);
		cfg_we    <= 1'b1;
		cfg_index <= REG_DECODE_MODE;
		cfg_data  <= {15'($urandom()), mode};
		@(posedge clk);
		cfg_index <= REG_ENC_DEBOUNCE;
		cfg_data  <= {8'($urandom()), enc_db};
		@(posedge clk);
		cfg_index <= REG_BTN_DEBOUNCE;
		cfg_data  <= btn_db;
		@(posedge clk);
		cfg_we     <= 1'b0;
		cfg_mode   = mode;
		cfg_enc_db = enc_db;
		cfg_btn_db = btn_db;
	endtask

	// mostly legal Gray walks with button presses, some pure noise
	task automatic send_walk_sample();
		int pick;
		pick = $urandom_range(99);
		if (pick < 8) begin
			send_sample(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
				$urandom());
		end else begin
			pick = $urandom_range(99);
			if (pick < 80)
				wall_ms += $urandom_range(8);
			else if (pick < 95)
				wall_ms += $urandom_range(300);
			else
				wall_ms += $urandom_range(140000);
			if ($urandom_range(99) < 15)
				turn_cw = !turn_cw;
			if ($urandom_range(99) < 70)
				gray_idx = turn_cw ? (gray_idx + 1) % 4 : (gray_idx + 3) % 4;
			if ($urandom_range(99) < 12)
				btn_drive = !btn_drive;
			send_sample(gray_idx == 1 || gray_idx == 2, gray_idx >= 2, btn_drive, wall_ms);
		end
	endtask

	task automatic run_phase(input logic mode, input logic [7:0] enc_db, input logic [15:0] btn_db,
		input int idle_pct, input int stall, input int count);
		drain();
		write_config(mode, enc_db, btn_db);
		sender_idle_pct = idle_pct;
		stall_pct <= stall;
		repeat (count)
			send_walk_sample();
		drain();
	endtask

	// reset config: full turns both ways, illegal jumps, button ignored
	task automatic test_table_decode();
		logic [1:0] ab_seq [11] = '{2'b10, 2'b11, 2'b01, 2'b00, 2'b10, 2'b11,
			2'b10, 2'b00, 2'b01, 2'b11, 2'b00};
		for (int i = 0; i < 11; i++)
			send_sample(ab_seq[i][1], ab_seq[i][0], i[0], $urandom());
		send_sample(1'b1, 1'b1, 1'b0, 32'hffff_ffff);
		send_sample(1'b1, 1'b1, 1'b1, 32'h0000_0000);
	endtask

	task automatic test_edge_decode();
		drain();
		write_config(MODE_EDGE, 8'd0, 16'd0);
		send_sample(1'b1, 1'b0, 1'b1, 32'd10);   // A rise: up
		send_sample(1'b0, 1'b0, 1'b1, 32'd10);
		send_sample(1'b0, 1'b1, 1'b1, 32'd11);   // B rise: down
		send_sample(1'b1, 1'b0, 1'b1, 32'd11);   // both pins flip
		send_sample(1'b0, 1'b1, 1'b1, 32'd11);   // B rise inside debounce
		send_sample(1'b0, 1'b0, 1'b0, 32'd20);   // press
		send_sample(1'b0, 1'b0, 1'b1, 32'd20);   // bounce, rejected
		send_sample(1'b0, 1'b0, 1'b0, 32'd21);
		send_sample(1'b0, 1'b0, 1'b1, 32'd30);   // release
		drain();
		write_config(MODE_EDGE, 8'd255, 16'd65535);
		send_sample(1'b0, 1'b0, 1'b1, 32'd100);
		send_sample(1'b1, 1'b0, 1'b1, 32'd276);  // just past debounce
		send_sample(1'b0, 1'b0, 1'b1, 32'd400);
		send_sample(1'b1, 1'b0, 1'b1, 32'd655);  // exactly at debounce
		send_sample(1'b1, 1'b0, 1'b0, 32'd65565);
		send_sample(1'b1, 1'b0, 1'b1, 32'd65566);
		send_sample(1'b1, 1'b0, 1'b0, 32'hffff_fff0);
		send_sample(1'b1, 1'b0, 1'b1, 32'h0001_0000); // release after wrap: duration 0
	endtask

	task automatic test_random_walk();
		run_phase(MODE_TABLE, 8'd1, 16'd5, 0, 0, 70);
		run_phase(MODE_EDGE, 8'd0, 16'd0, 68, 0, 70);
		run_phase(MODE_EDGE, 8'd255, 16'd65535, 0, 68, 70);
		run_phase(MODE_EDGE, 8'($urandom_range(6)), 16'($urandom_range(400)), 32, 32, 70);
		run_phase(MODE_TABLE, 8'($urandom()), 16'($urandom()), 32, 32, 60);
		run_phase(MODE_EDGE, 8'd3, 16'd10, 0, 0, 40);
	endtask

	// long output hold-off with the input still pushing, then a full drain mid-stream
	task automatic test_backpressure();
		drain();
		write_config(MODE_EDGE, 8'd2, 16'd20);
		sender_idle_pct = 0;
		stall_pct   <= 0;
		hold_toggle <= !hold_toggle;
		repeat (24)
			send_walk_sample();
		drain();
		repeat (24)
			send_walk_sample();
		drain();
	endtask

	initial begin
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		arst_n    = 1'b0;
		reset_decoder();
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		test_table_decode();
		test_edge_decode();
		test_random_walk();
		test_backpressure();
		drain();
		repeat (8)
			@(posedge clk);
		if (mismatch_count == 0)
			$display("rotary_encoder_front_end test passed");
		else
			$display("rotary_encoder_front_end test failed");
		$finish;
	end

endmodule

// File: files.f
rtl/renc_pkg.sv
rtl/rotary_encoder_front_end.sv
tb/sv/rotary_encoder_front_end_tb.sv
